FILE: rtl/core/nefrm_pkg.sv
// Package for the neutron event pixel and frame tagger.
// Holds command, status and register codes, widths and shared types.
// No dependencies.
`timescale 1ns / 1ps

package nefrm_pkg;

	localparam int MAP_DEPTH_DEF   = 65536;
	localparam int PULSE_DEPTH_DEF = 65536;
	localparam int FRAME_LIMIT     = 65536;

	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 17;
	localparam int S_DATA_W  = 112;
	localparam int M_DATA_W  = 272;

	localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MAP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PULSE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FILT  = 2'd3;

	localparam logic [STATUS_W-1:0] STS_GOOD  = 2'd0;
	localparam logic [STATUS_W-1:0] STS_ERROR = 2'd1;
	localparam logic [STATUS_W-1:0] STS_IGN   = 2'd2;
	localparam logic [STATUS_W-1:0] STS_WRITE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_USE_MAPPING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_PIXELS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_PULSES  = 2'd3;

	localparam int ERR_BIT = 31;

	typedef struct packed {
		logic [30:0] quot;
		logic [16:0] rem;
	} div_res_t;

endpackage

FILE: rtl/core/nefrm_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nefrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/nefrm_div.sv
// Serial restoring divider, one quotient bit per cycle, 32 by 17 bits.
// Depends on nefrm_pkg.
`timescale 1ns / 1ps

module nefrm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       dividend,
	input  logic [16:0]       divisor,
	output logic              done,
	output nefrm_pkg::div_res_t res
);
	import nefrm_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] quot_q;
	logic [16:0] rem_q;
	logic [16:0] dvs_q;
	logic [17:0] trial;
	logic        fits;

	assign trial = {rem_q, quot_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[30:0], fits};
			rem_q  <= fits ? 17'(trial - {1'b0, dvs_q}) : trial[16:0];
		end
	end

	assign done     = done_q;
	assign res.quot = quot_q[30:0];
	assign res.rem  = rem_q;

endmodule

FILE: rtl/core/neutron_event_pixel_frame_tagger_unit.sv
// Neutron event pixel and frame tagger, top level.
// Depends on nefrm_pkg, nefrm_ram and nefrm_div.
// After reset the filter bitmap is cleared one entry per cycle, and no request is accepted
// until that pass ends; configuration writes are taken throughout. One request is worked
// on at a time. A table write passes through ST_WRITE and ST_DONE before the next request
// can be taken. An event passes through these steps in order: the serial period division
// when mapping is on, the pixel map read when the remainder lies inside the map, the filter
// bitmap read when filtering a pixel inside the map, and, when the frame can still advance,
// a read of the current pulse start entry and then one read per pulse start entry examined
// by the single read port of the pulse table. The next request is accepted while a result
// still waits in the output register; a finished result that cannot enter the output
// register holds the block.
`timescale 1ns / 1ps

module neutron_event_pixel_frame_tagger_unit #(
	parameter int MAP_DEPTH   = nefrm_pkg::MAP_DEPTH_DEF,
	parameter int PULSE_DEPTH = nefrm_pkg::PULSE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [nefrm_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [nefrm_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// raw_pid, raw_tof, table_addr, table_data
	input  logic [nefrm_pkg::S_DATA_W-1:0]      s_tdata,
	// cmd
	input  logic [nefrm_pkg::CMD_W-1:0]         s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// pixel_id, period, frame, tof, min_tof, max_tof, good_count,
	// error_count, ignored_count, zero fill
	output logic [nefrm_pkg::M_DATA_W-1:0]      m_tdata,
	// status
	output logic [nefrm_pkg::STATUS_W-1:0]      m_tuser
);
	import nefrm_pkg::*;

	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int PULSE_AW  = $clog2(PULSE_DEPTH);
	localparam int PULSE_LIM = (PULSE_DEPTH < FRAME_LIMIT) ? PULSE_DEPTH : FRAME_LIMIT;

	typedef enum logic [14:0] {
		ST_CLR     = 15'b000000000000001,
		ST_IDLE    = 15'b000000000000010,
		ST_WRITE   = 15'b000000000000100,
		ST_DIV     = 15'b000000000001000,
		ST_MAP_RD  = 15'b000000000010000,
		ST_MAP_WT  = 15'b000000000100000,
		ST_FLT_CHK = 15'b000000001000000,
		ST_FLT_RD  = 15'b000000010000000,
		ST_FLT_WT  = 15'b000000100000000,
		ST_FRM_CHK = 15'b000001000000000,
		ST_BASE_RD = 15'b000010000000000,
		ST_BASE_WT = 15'b000100000000000,
		ST_NX_RD   = 15'b001000000000000,
		ST_NX_WT   = 15'b010000000000000,
		ST_DONE    = 15'b100000000000000
	} state_t;

	state_t state_q;

	logic        use_mapping_q;
	logic [16:0] num_pixels_q;
	logic        filter_en_q;
	logic [16:0] num_pulses_q;

	logic [CMD_W-1:0] cmd_q;
	logic [31:0]      tof_q;
	logic [15:0]      taddr_q;
	logic [31:0]      tdat_q;

	logic [31:0]         ev_cnt_q;
	logic [31:0]         ev_index_q;
	logic [15:0]         frame_q;
	logic [31:0]         tof_low_q;
	logic [31:0]         tof_high_q;
	logic [31:0]         good_total_q;
	logic [31:0]         err_total_q;
	logic [31:0]         ign_total_q;
	logic [STATUS_W-1:0] res_sts_q;
	logic [30:0]         px_q;
	logic [30:0]         per_q;
	logic [16:0]         rem_q;
	logic [31:0]         base_q;
	logic [16:0]         nx_q;
	logic [MAP_AW-1:0]   clr_cnt_q;

	logic                m_valid_q;
	logic [STATUS_W-1:0] o_sts_q;
	logic [30:0]         o_pix_q;
	logic [30:0]         o_per_q;
	logic [15:0]         o_frm_q;
	logic [31:0]         o_tof_q;
	logic [31:0]         o_min_q;
	logic [31:0]         o_max_q;
	logic [31:0]         o_good_q;
	logic [31:0]         o_err_q;
	logic [31:0]         o_ign_q;

	logic        accept;
	logic        out_load;
	logic        div_start;
	logic        div_done;
	div_res_t    div_res;
	logic [16:0] divisor;
	logic [16:0] n_use;
	logic [16:0] last_p1;
	logic        addr_in_map;
	logic        addr_in_pulse;

	logic                map_we;
	logic [16:0]         map_rdata;
	logic                pul_we;
	logic [PULSE_AW-1:0] pul_raddr;
	logic [31:0]         pul_rdata;
	logic                flt_we;
	logic [MAP_AW-1:0]   flt_waddr;
	logic                flt_wdata;
	logic                flt_rdata;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_DONE) && (!m_valid_q || m_tready);
	assign div_start = accept && (s_tuser == CMD_EVENT) && !s_tdata[ERR_BIT] && use_mapping_q;
	assign divisor   = (num_pixels_q == '0) ? 17'd1 : num_pixels_q;
	assign n_use     = (num_pulses_q > 17'(PULSE_LIM)) ? 17'(PULSE_LIM) : num_pulses_q;
	assign last_p1   = {1'b0, frame_q} + 17'd1;

	assign addr_in_map   = {16'd0, taddr_q} < 32'(MAP_DEPTH);
	assign addr_in_pulse = {16'd0, taddr_q} < 32'(PULSE_DEPTH);

	assign map_we    = (state_q == ST_WRITE) && (cmd_q == CMD_MAP) && addr_in_map;
	assign pul_we    = (state_q == ST_WRITE) && (cmd_q == CMD_PULSE) && addr_in_pulse;
	assign pul_raddr = (state_q == ST_BASE_RD) ? PULSE_AW'(frame_q) : PULSE_AW'(nx_q);
	assign flt_we    = (state_q == ST_CLR) ||
		((state_q == ST_WRITE) && (cmd_q == CMD_FILT) && addr_in_map);
	assign flt_waddr = (state_q == ST_CLR) ? clr_cnt_q : MAP_AW'(taddr_q);
	assign flt_wdata = (state_q == ST_CLR) ? 1'b0 : tdat_q[0];

	nefrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (s_tdata[31:0]),
		.divisor  (divisor),
		.done     (div_done),
		.res      (div_res)
	);

	nefrm_ram #(.WIDTH(17), .DEPTH(MAP_DEPTH)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (MAP_AW'(taddr_q)),
		.wdata (tdat_q[16:0]),
		.raddr (MAP_AW'(rem_q)),
		.rdata (map_rdata)
	);

	nefrm_ram #(.WIDTH(32), .DEPTH(PULSE_DEPTH)) u_pulse_ram (
		.clk   (clk),
		.we    (pul_we),
		.waddr (PULSE_AW'(taddr_q)),
		.wdata (tdat_q),
		.raddr (pul_raddr),
		.rdata (pul_rdata)
	);

	nefrm_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_filter_ram (
		.clk   (clk),
		.we    (flt_we),
		.waddr (flt_waddr),
		.wdata (flt_wdata),
		.raddr (MAP_AW'(px_q)),
		.rdata (flt_rdata)
	);

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == '1) ? v : v + 32'd1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_mapping_q <= 1'b0;
			num_pixels_q  <= 17'd1;
			filter_en_q   <= 1'b0;
			num_pulses_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_USE_MAPPING: use_mapping_q <= cfg_wdata[0];
				CFG_NUM_PIXELS:  num_pixels_q  <= cfg_wdata;
				CFG_FILTER_EN:   filter_en_q   <= cfg_wdata[0];
				CFG_NUM_PULSES:  num_pulses_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_tuser;
			tof_q   <= s_tdata[63:32];
			taddr_q <= s_tdata[79:64];
			tdat_q  <= s_tdata[111:80];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_cnt_q    <= '0;
			ev_cnt_q     <= '0;
			frame_q      <= '0;
			tof_low_q    <= '1;
			tof_high_q   <= '0;
			good_total_q <= '0;
			err_total_q  <= '0;
			ign_total_q  <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + MAP_AW'(1);
					if (clr_cnt_q == MAP_AW'(MAP_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser != CMD_EVENT) begin
							state_q <= ST_WRITE;
						end else begin
							ev_index_q <= ev_cnt_q;
							ev_cnt_q   <= ev_cnt_q + 32'd1;
							if (s_tdata[ERR_BIT]) begin
								err_total_q <= sat_inc(err_total_q);
								res_sts_q   <= STS_ERROR;
								state_q     <= ST_DONE;
							end else if (use_mapping_q) begin
								state_q <= ST_DIV;
							end else begin
								px_q    <= s_tdata[30:0];
								per_q   <= '0;
								state_q <= ST_FLT_CHK;
							end
						end
					end
				end
				ST_WRITE: begin
					res_sts_q <= STS_WRITE;
					state_q   <= ST_DONE;
				end
				ST_DIV: begin
					if (div_done) begin
						per_q <= div_res.quot;
						rem_q <= div_res.rem;
						if ({15'd0, div_res.rem} < 32'(MAP_DEPTH)) begin
							state_q <= ST_MAP_RD;
						end else begin
							px_q    <= '0;
							state_q <= ST_FLT_CHK;
						end
					end
				end
				ST_MAP_RD: state_q <= ST_MAP_WT;
				ST_MAP_WT: begin
					px_q    <= {14'd0, map_rdata};
					state_q <= ST_FLT_CHK;
				end
				ST_FLT_CHK: begin
					if (!filter_en_q) begin
						state_q <= ST_FRM_CHK;
					end else if ({1'b0, px_q} >= 32'(MAP_DEPTH)) begin
						ign_total_q <= sat_inc(ign_total_q);
						res_sts_q   <= STS_IGN;
						state_q     <= ST_DONE;
					end else begin
						state_q <= ST_FLT_RD;
					end
				end
				ST_FLT_RD: state_q <= ST_FLT_WT;
				ST_FLT_WT: begin
					if (flt_rdata) begin
						state_q <= ST_FRM_CHK;
					end else begin
						ign_total_q <= sat_inc(ign_total_q);
						res_sts_q   <= STS_IGN;
						state_q     <= ST_DONE;
					end
				end
				ST_FRM_CHK: begin
					if (last_p1 >= n_use) begin
						tof_low_q    <= (tof_q < tof_low_q) ? tof_q : tof_low_q;
						tof_high_q   <= (tof_q > tof_high_q) ? tof_q : tof_high_q;
						good_total_q <= sat_inc(good_total_q);
						res_sts_q    <= STS_GOOD;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_BASE_RD;
					end
				end
				ST_BASE_RD: state_q <= ST_BASE_WT;
				ST_BASE_WT: begin
					base_q  <= pul_rdata;
					nx_q    <= last_p1;
					state_q <= ST_NX_RD;
				end
				ST_NX_RD: state_q <= ST_NX_WT;
				ST_NX_WT: begin
					if ((nx_q < (n_use - 17'd1)) && (pul_rdata <= base_q)) begin
						nx_q    <= nx_q + 17'd1;
						state_q <= ST_NX_RD;
					end else begin
						if (pul_rdata <= ev_index_q) begin
							frame_q <= nx_q[15:0];
						end
						tof_low_q    <= (tof_q < tof_low_q) ? tof_q : tof_low_q;
						tof_high_q   <= (tof_q > tof_high_q) ? tof_q : tof_high_q;
						good_total_q <= sat_inc(good_total_q);
						res_sts_q    <= STS_GOOD;
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_sts_q  <= res_sts_q;
			o_pix_q  <= (res_sts_q == STS_GOOD) ? px_q : '0;
			o_per_q  <= (res_sts_q == STS_GOOD) ? per_q : '0;
			o_frm_q  <= (res_sts_q == STS_GOOD) ? frame_q : '0;
			o_tof_q  <= (res_sts_q == STS_GOOD) ? tof_q : '0;
			o_min_q  <= tof_low_q;
			o_max_q  <= tof_high_q;
			o_good_q <= good_total_q;
			o_err_q  <= err_total_q;
			o_ign_q  <= ign_total_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = o_sts_q;
	assign m_tdata  = {2'b00, o_ign_q, o_err_q, o_good_q, o_max_q, o_min_q,
		o_tof_q, o_frm_q, o_per_q, o_pix_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !s_tready)
		else $error("request accepted during filter clear");

	assert property (@(posedge clk) disable iff (!arst_n)
		(good_total_q != '0) |-> (tof_low_q <= tof_high_q))
		else $error("tof range inverted");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NX_WT) |-> (nx_q < n_use))
		else $error("frame search past usable pulses");

endmodule
